>>> hw/rtl/mlcd_pkg.sv
// ----------------------------------------------------------------------------
// mlcd_pkg
// shared types and register codes of the monochrome lcd frame store controller
// ----------------------------------------------------------------------------
`default_nettype none

package mlcd_pkg;

  typedef enum logic [1:0] {
    OP_SELECT = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  localparam logic [2:0] ADDR_REG = 3'd4;
  localparam logic [2:0] DATA_REG = 3'd7;
  localparam logic [7:0] ROW_MARK = 8'hc0;

  localparam int ROW_W = 6;
  localparam int COL_W = 4;

  // memory access request from the cursor logic
  typedef struct packed {
    logic wr;
    logic rd;
    logic flag;
  } acc_t;

endpackage

`default_nettype wire

>>> hw/rtl/mlcd_gram.sv
// ----------------------------------------------------------------------------
// mlcd_gram
// frame store memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mlcd_gram #(
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [7:0]               wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mlcd_cursor.sv
// ----------------------------------------------------------------------------
// mlcd_cursor
// register index, row and column cursor, frame store address and access kind
// ----------------------------------------------------------------------------
`default_nettype none

module mlcd_cursor #(
  parameter int ROWS          = 64,
  parameter int BYTES_PER_ROW = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     accept,
  input  wire logic [1:0]                               operation,
  input  wire logic [7:0]                               value,
  output mlcd_pkg::acc_t                                acc,
  output logic [$clog2(ROWS*BYTES_PER_ROW)-1:0]         addr
);

  localparam int AW = $clog2(ROWS * BYTES_PER_ROW);

  logic [2:0]                  reg_index, reg_index_next;
  logic [mlcd_pkg::ROW_W-1:0]  row, row_next;
  logic [mlcd_pkg::COL_W-1:0]  col, col_next;
  mlcd_pkg::op_t               op;

  function automatic logic [mlcd_pkg::ROW_W-1:0] row_wrap(
    input logic [mlcd_pkg::ROW_W-1:0] r
  );
    logic [8:0] v;
    v = 9'(r);
    for (int i = 0; i < 8; i++) begin
      if (v >= 9'(ROWS)) begin
        v = v - 9'(ROWS);
      end
    end
    return v[mlcd_pkg::ROW_W-1:0];
  endfunction

  function automatic logic [mlcd_pkg::COL_W-1:0] col_wrap(
    input logic [mlcd_pkg::COL_W-1:0] c
  );
    logic [6:0] v;
    v = 7'(c);
    for (int i = 0; i < 8; i++) begin
      if (v >= 7'(BYTES_PER_ROW)) begin
        v = v - 7'(BYTES_PER_ROW);
      end
    end
    return v[mlcd_pkg::COL_W-1:0];
  endfunction

  assign op   = mlcd_pkg::op_t'(operation);
  assign addr = AW'(32'(row) * BYTES_PER_ROW + 32'(col));

  always_comb begin
    reg_index_next = reg_index;
    row_next       = row;
    col_next       = col;
    acc            = '0;
    if (accept) begin
      unique case (op)
        mlcd_pkg::OP_SELECT: begin
          reg_index_next = value[2:0];
        end
        mlcd_pkg::OP_WRITE: begin
          if (reg_index == mlcd_pkg::ADDR_REG) begin
            if ((value & mlcd_pkg::ROW_MARK) == mlcd_pkg::ROW_MARK) begin
              row_next = row_wrap(value[mlcd_pkg::ROW_W-1:0]);
            end else begin
              col_next = col_wrap(value[mlcd_pkg::COL_W-1:0]);
            end
          end else if (reg_index == mlcd_pkg::DATA_REG) begin
            acc.wr = 1'b1;
          end
        end
        mlcd_pkg::OP_READ: begin
          acc.flag = 1'b1;
          if (reg_index == mlcd_pkg::DATA_REG) begin
            acc.rd = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (acc.wr || acc.rd) begin
        if (7'(col) + 7'd1 >= 7'(BYTES_PER_ROW)) begin
          col_next = '0;
        end else begin
          col_next = col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_index <= '0;
      row       <= '0;
      col       <= '0;
    end else begin
      reg_index <= reg_index_next;
      row       <= row_next;
      col       <= col_next;
    end
  end

`ifndef SYNTHESIS
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    9'(row) < 9'(ROWS))
    else $error("row out of range");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    7'(col) < 7'(BYTES_PER_ROW))
    else $error("column out of range");

  a_col_step: assert property (@(posedge clk) disable iff (rst)
    (acc.wr || acc.rd) |=> (col != $past(col) || BYTES_PER_ROW == 1))
    else $error("column did not step on data transfer");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/mono_lcd_gram_controller.sv
// each input transfer gives one result, which passes the registered frame store
// read (alongside the s1 stage registers) and then the output register
// throughput: one access per cycle while m_tready does not stall the output and no clearing pass runs
// reset: control state clears at once, then a clearing pass writes zero to all
// ROWS*BYTES_PER_ROW frame store entries, one per cycle, with s_tready low
// ----------------------------------------------------------------------------
// mono_lcd_gram_controller
// monochrome lcd controller: register select, cursor and frame store access
// ----------------------------------------------------------------------------
`default_nettype none

module mono_lcd_gram_controller #(
  parameter int ROWS          = 64,
  parameter int BYTES_PER_ROW = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // operation[1:0], value[9:2], zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // read_data[7:0]
  output logic             m_tuser    // read_valid[0]
);

  localparam int DEPTH = ROWS * BYTES_PER_ROW;
  localparam int AW    = $clog2(DEPTH);

  logic            clearing;
  logic [AW-1:0]   clr_cnt;
  logic            accept;
  mlcd_pkg::acc_t  acc;
  logic [AW-1:0]   addr;
  logic [7:0]      mem_rdata;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [7:0]      mem_wdata;

  logic            s1_valid;
  logic            s1_user;
  logic            s1_mem;
  logic            s1_adv;

  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !clearing && (!s1_valid || s1_adv);
  assign accept   = s_tvalid && s_tready;

  assign mem_we    = clearing || acc.wr;
  assign mem_waddr = clearing ? clr_cnt : addr;
  assign mem_wdata = clearing ? 8'd0 : s_tdata[9:2];

  mlcd_cursor #(
    .ROWS          (ROWS),
    .BYTES_PER_ROW (BYTES_PER_ROW)
  ) u_cursor (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (s_tdata[1:0]),
    .value     (s_tdata[9:2]),
    .acc       (acc),
    .addr      (addr)
  );

  mlcd_gram #(
    .DEPTH (DEPTH)
  ) u_gram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (acc.rd),
    .raddr (addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_user <= acc.flag;
      s1_mem  <= acc.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= s1_mem ? mem_rdata : 8'd0;
      m_tuser <= s1_user;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("transfer accepted during clearing pass");

  a_accept_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted transfer lost");

  a_mem_is_read: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_mem |-> s1_user)
    else $error("memory data on non-read result");

  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 8'd0)
    else $error("nonzero data on non-read result");
`endif

endmodule

`default_nettype wire
